/* sv/packed_4bpp_raster_engine_assert.svh */
// Assertion macros for the packed 4bpp raster engine.
`ifndef PACKED_4BPP_RASTER_ENGINE_ASSERT_SVH
`define PACKED_4BPP_RASTER_ENGINE_ASSERT_SVH

// Assert that a condition implies a consequence in the same cycle.
`define P4R_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define P4R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/p4r_pkg.sv */
// Package: opcodes, register indexes and the configuration word width of the packed 4bpp raster engine.
package p4r_pkg;
  localparam int CFG_W = 16;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_READ  = 3'd1,
    OP_HLINE = 3'd2,
    OP_VLINE = 3'd3,
    OP_COPY  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_LINE     = 3'd2,
    REG_MODE     = 3'd3,
    REG_SRC_BASE = 3'd4,
    REG_SRC_LINE = 3'd5
  } reg_idx_t;
endpackage

/* sv/p4r_addr_unit.sv */
// Shared address unit: base + (x >> 1) + y * stride, registered, wrapped modulo 2^AW.
module p4r_addr_unit #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic [15:0]   base,
  input  logic [10:0]   px,
  input  logic [10:0]   py,
  input  logic [9:0]    stride,
  output logic [AW-1:0] addr_r
);
  logic [AW-1:0] addr_nxt;
  logic [20:0]   prod;

  // One multiply and add per use; wraps modulo 2^AW
  always_comb begin
    prod     = py * stride;
    addr_nxt = AW'(({16'd0, base} + {22'd0, px[10:1]} + {11'd0, prod}) & {32{1'b1}});
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end
endmodule

/* sv/packed_4bpp_raster_engine.sv */
// Packed 4bpp raster engine: one command at a time, one pixel per
// read-modify-write of the frame store through a shared address unit.
// Each pixel takes an address step, a store read and a write back; a copy
// first reads its source pixel the same way, as the store has one port.
// After reset the store is cleared one byte a cycle while in_ready
// stays low; configuration writes are taken throughout.
module packed_4bpp_raster_engine #(
  parameter int FB_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [p4r_pkg::CFG_W-1:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [9:0]  in_x,
  input  logic [9:0]  in_y,
  input  logic [10:0] in_x_end,
  input  logic [10:0] in_y_end,
  input  logic [9:0]  in_src_x,
  input  logic [9:0]  in_src_y,
  input  logic [3:0]  in_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_pixel_value,
  output logic        out_status
);
  import p4r_pkg::*;
  `include "packed_4bpp_raster_engine_assert.svh"

  localparam int AW = $clog2(FB_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SADDR, S_SRD, S_SDATA,
    S_DADDR, S_DRD, S_DWR, S_NEXT, S_DONE
  } state_t;

  // Configuration registers
  logic [10:0] width_r, height_r;
  logic [9:0]  line_r, src_line_r;
  logic        mode_r;
  logic [15:0] src_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 11'd320;
      height_r   <= 11'd240;
      line_r     <= 10'd160;
      mode_r     <= 1'b0;
      src_base_r <= 16'd0;
      src_line_r <= 10'd160;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:    width_r    <= cfg_wdata[10:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[10:0];
        REG_LINE:     line_r     <= cfg_wdata[9:0];
        REG_MODE:     mode_r     <= cfg_wdata[0];
        REG_SRC_BASE: src_base_r <= cfg_wdata[15:0];
        REG_SRC_LINE: src_line_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Command registers
  state_t      state_r;
  logic [2:0]  op_r;
  logic [10:0] x_r, y_r, xe_r, ye_r, sx_r, sy_r;
  logic [3:0]  color_r, pix_r;
  logic [10:0] i_r, j_r;
  logic [AW-1:0] clr_r, addr_hold_r;
  logic        is_src_r;
  logic [3:0]  pv_r;
  logic        st_r;

  // Shared address unit operands
  logic [15:0] au_base;
  logic [10:0] au_px, au_py;
  logic [9:0]  au_stride;
  logic [AW-1:0] au_addr;

  always_comb begin
    if (is_src_r) begin
      au_base   = src_base_r;
      au_px     = sx_r + i_r;
      au_py     = sy_r + j_r;
      au_stride = src_line_r;
    end else begin
      au_base   = 16'd0;
      au_px     = x_r + i_r;
      au_py     = y_r + j_r;
      au_stride = line_r;
    end
  end

  p4r_addr_unit #(.AW(AW)) u_addr (
    .clk(clk), .base(au_base), .px(au_px), .py(au_py),
    .stride(au_stride), .addr_r(au_addr)
  );

  // Frame store, single port, registered read
  logic [7:0] mem [FB_BYTES];
  logic [7:0] rdata_r;
  logic       mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  // Bounds check
  logic ok;
  logic [11:0] cx, cy, csx, csy;
  always_comb begin
    cx  = {1'b0, x_r} + {1'b0, xe_r};
    cy  = {1'b0, y_r} + {1'b0, ye_r};
    csx = {1'b0, sx_r} + {1'b0, xe_r};
    csy = {1'b0, sy_r} + {1'b0, ye_r};
    unique case (op_r)
      OP_SET, OP_READ: ok = (x_r < width_r) && (y_r < height_r);
      OP_HLINE: ok = (x_r <= xe_r) && (xe_r < width_r) && (y_r < height_r);
      OP_VLINE: ok = (x_r < width_r) && (y_r <= ye_r) && (ye_r < height_r);
      OP_COPY:  ok = (xe_r != 11'd0) && (ye_r != 11'd0)
                  && (cx <= {1'b0, width_r}) && (cy <= {1'b0, height_r})
                  && (csx <= {1'b0, width_r}) && (csy <= {1'b0, height_r});
      default:  ok = 1'b0;
    endcase
  end

  // Pixel position and nibble merge
  logic [10:0] dpx;
  logic [3:0]  new_nib, old_nib;
  always_comb begin
    dpx     = x_r + i_r;
    old_nib = dpx[0] ? rdata_r[3:0] : rdata_r[7:4];
    if (op_r == OP_COPY)  new_nib = pix_r;
    else if (mode_r)      new_nib = old_nib ^ color_r;
    else                  new_nib = color_r;
    mem_we    = 1'b0;
    mem_addr  = addr_hold_r;
    mem_wdata = dpx[0] ? {rdata_r[7:4], new_nib} : {new_nib, rdata_r[3:0]};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_r;
      mem_wdata = 8'd0;
    end else if (state_r == S_DWR) begin
      // the read command must not write the store
      mem_we = (op_r != OP_READ);
    end else if (state_r == S_SRD || state_r == S_DRD) begin
      mem_addr = au_addr;
    end
  end

  // Walk end tests
  logic last_col, last_row;
  always_comb begin
    unique case (op_r)
      OP_HLINE: begin last_col = (x_r + i_r) == xe_r; last_row = 1'b1; end
      OP_VLINE: begin last_col = 1'b1; last_row = (y_r + j_r) == ye_r; end
      OP_COPY:  begin last_col = (i_r + 11'd1) == xe_r; last_row = (j_r + 11'd1) == ye_r; end
      default:  begin last_col = 1'b1; last_row = 1'b1; end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      is_src_r <= 1'b0;
      st_r     <= 1'b0;
      pv_r     <= 4'd0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(FB_BYTES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            x_r     <= {1'b0, in_x};
            y_r     <= {1'b0, in_y};
            xe_r    <= in_x_end;
            ye_r    <= in_y_end;
            sx_r    <= {1'b0, in_src_x};
            sy_r    <= {1'b0, in_src_y};
            color_r <= in_color;
            i_r     <= 11'd0;
            j_r     <= 11'd0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          pv_r <= 4'd0;
          st_r <= !ok;
          if (!ok) state_r <= S_DONE;
          else if (op_r == OP_COPY) begin
            is_src_r <= 1'b1;
            state_r  <= S_SADDR;
          end else begin
            is_src_r <= 1'b0;
            state_r  <= S_DADDR;
          end
        end
        S_SADDR: state_r <= S_SRD;
        S_SRD:   state_r <= S_SDATA;
        S_SDATA: begin
          pix_r    <= (sx_r[0] ^ i_r[0]) ? rdata_r[3:0] : rdata_r[7:4];
          is_src_r <= 1'b0;
          state_r  <= S_DADDR;
        end
        S_DADDR: state_r <= S_DRD;
        S_DRD: begin
          addr_hold_r <= au_addr;
          state_r     <= S_DWR;
        end
        S_DWR: begin
          if (op_r == OP_READ) begin
            pv_r    <= old_nib;
            state_r <= S_DONE;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (last_col && last_row) state_r <= S_DONE;
          else begin
            if (last_col) begin
              i_r <= 11'd0;
              j_r <= j_r + 11'd1;
            end else begin
              i_r <= i_r + 11'd1;
            end
            is_src_r <= (op_r == OP_COPY);
            state_r  <= (op_r == OP_COPY) ? S_SADDR : S_DADDR;
          end
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Handshake and result outputs
  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_pixel_value = pv_r;
  assign out_status      = st_r;

  `P4R_ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
  `P4R_ASSERT_IMPL(a_reject_zero, out_valid && out_status, out_pixel_value == 4'd0)
  `P4R_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)
endmodule
